// ----- design/kst_pkg.sv -----
// kst_pkg: shared types, constants and helpers for the keyboard scancode tracker
// depends on nothing

package kst_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [6:0]      key_t;

  localparam logic [7:0] PrefixByte = 8'hE0;

  localparam key_t CodeCaps   = 7'd58;
  localparam key_t CodeNum    = 7'd69;
  localparam key_t CodeScroll = 7'd70;
  localparam key_t CodeCtrl   = 7'd29;
  localparam key_t CodeLShift = 7'd42;
  localparam key_t CodeRShift = 7'd54;
  localparam key_t CodeAlt    = 7'd56;
  localparam key_t CodeLMeta  = 7'd91;
  localparam key_t CodeRMeta  = 7'd92;

  localparam logic KindByte = 1'b0;
  localparam logic KindPop  = 1'b1;

  localparam logic [2:0] ModCtrl   = 3'd0;
  localparam logic [2:0] ModAlt    = 3'd1;
  localparam logic [2:0] ModShift  = 3'd2;
  localparam logic [2:0] ModMeta   = 3'd3;
  localparam logic [2:0] ModCaps   = 3'd4;
  localparam logic [2:0] ModNum    = 3'd5;
  localparam logic [2:0] ModScroll = 3'd6;

  localparam int unsigned LockCaps   = 0;
  localparam int unsigned LockNum    = 1;
  localparam int unsigned LockScroll = 2;

  typedef struct packed {
    logic       kind;
    logic [7:0] scancode;
    key_t       query_key;
    logic [2:0] modifier_index;
  } in_word_t;

  typedef struct packed {
    key_t popped_code;
    logic popped_valid;
    logic queue_nonempty;
    logic press_dropped;
    logic key_is_down;
    logic modifier_active;
  } out_word_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    if (p == ptr_t'(QueueDepth - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

endpackage

// ----- design/kst_if.sv -----
// kst_in_if, kst_out_if: valid/ready channels of the scancode tracker
// depends on kst_pkg

interface kst_in_if
  import kst_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] scancode;
  logic [6:0] query_key;
  logic [2:0] modifier_index;

  modport source (output valid, kind, scancode, query_key, modifier_index, input ready);
  modport sink   (input valid, kind, scancode, query_key, modifier_index, output ready);
endinterface

interface kst_out_if
  import kst_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [6:0] popped_code;
  logic       popped_valid;
  logic       queue_nonempty;
  logic       press_dropped;
  logic       key_is_down;
  logic       modifier_active;

  modport source (output valid, popped_code, popped_valid, queue_nonempty, press_dropped,
                  key_is_down, modifier_active, input ready);
  modport sink   (input valid, popped_code, popped_valid, queue_nonempty, press_dropped,
                  key_is_down, modifier_active, output ready);
endinterface

// ----- design/keyboard_scancode_tracker.sv -----
// keyboard_scancode_tracker: set-1 scancode tracker with press queue, key map and locks
// path: input register, then the single update stage, then the output register
// throughput: one word per cycle unless the output stalls, set by the single update stage
// reset: valid flags, pointers, key-down map, lock and just-locked flags cleared at once; ring unset
// depends on kst_pkg, kst_in_if, kst_out_if

module keyboard_scancode_tracker
  import kst_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  kst_in_if.sink    in_i,
  kst_out_if.source out_o
);

  logic      s1_valid_q;
  in_word_t  s1_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t out_word_d;

  key_t         ring_q [QueueDepth];
  ptr_t         wr_ptr_q, wr_ptr_d;
  ptr_t         rd_ptr_q, rd_ptr_d;
  logic [127:0] down_q, down_d;
  logic [2:0]   lock_q, lock_d;
  logic [2:0]   just_q, just_d;
  logic         ring_we;

  logic s1_fire;
  logic in_fire;
  logic is_press;
  logic is_release;
  key_t code;

  assign s1_fire  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;

  assign code       = s1_word_q.scancode[6:0];
  assign is_press   = (s1_word_q.kind == KindByte) && (s1_word_q.scancode != PrefixByte)
                      && !s1_word_q.scancode[7];
  assign is_release = (s1_word_q.kind == KindByte) && (s1_word_q.scancode != PrefixByte)
                      && s1_word_q.scancode[7];

  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    down_d     = down_q;
    lock_d     = lock_q;
    just_d     = just_q;
    ring_we    = 1'b0;
    out_word_d = '0;
    if (s1_word_q.kind == KindPop) begin
      if (wr_ptr_q != rd_ptr_q) begin
        out_word_d.popped_code  = ring_q[rd_ptr_q];
        out_word_d.popped_valid = 1'b1;
        rd_ptr_d = ptr_next(rd_ptr_q);
      end
    end else if (is_press) begin
      if (ptr_next(wr_ptr_q) != rd_ptr_q) begin
        ring_we  = 1'b1;
        wr_ptr_d = ptr_next(wr_ptr_q);
      end else begin
        out_word_d.press_dropped = 1'b1;
      end
      priority if (!lock_q[LockCaps] && code == CodeCaps) begin
        lock_d[LockCaps] = 1'b1;
        just_d[LockCaps] = 1'b1;
      end else if (!lock_q[LockNum] && code == CodeNum) begin
        lock_d[LockNum] = 1'b1;
        just_d[LockNum] = 1'b1;
      end else if (!lock_q[LockScroll] && code == CodeScroll) begin
        lock_d[LockScroll] = 1'b1;
        just_d[LockScroll] = 1'b1;
      end else begin
      end
      down_d[code] = 1'b1;
    end else if (is_release) begin
      priority if (!just_q[LockCaps] && code == CodeCaps) begin
        lock_d[LockCaps] = 1'b0;
      end else if (!just_q[LockNum] && code == CodeNum) begin
        lock_d[LockNum] = 1'b0;
      end else if (!just_q[LockScroll] && code == CodeScroll) begin
        lock_d[LockScroll] = 1'b0;
      end else begin
      end
      just_d       = '0;
      down_d[code] = 1'b0;
    end

    out_word_d.queue_nonempty = (wr_ptr_d != rd_ptr_d);
    out_word_d.key_is_down    = down_d[s1_word_q.query_key];
    unique case (s1_word_q.modifier_index)
      ModCtrl:   out_word_d.modifier_active = down_d[CodeCtrl];
      ModAlt:    out_word_d.modifier_active = down_d[CodeAlt];
      ModShift:  out_word_d.modifier_active = down_d[CodeLShift] | down_d[CodeRShift];
      ModMeta:   out_word_d.modifier_active = down_d[CodeLMeta] | down_d[CodeRMeta];
      ModCaps:   out_word_d.modifier_active = lock_d[LockCaps];
      ModNum:    out_word_d.modifier_active = lock_d[LockNum];
      ModScroll: out_word_d.modifier_active = lock_d[LockScroll];
      default:   out_word_d.modifier_active = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      down_q      <= '0;
      lock_q      <= '0;
      just_q      <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        wr_ptr_q    <= wr_ptr_d;
        rd_ptr_q    <= rd_ptr_d;
        down_q      <= down_d;
        lock_q      <= lock_d;
        just_q      <= just_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q.kind           <= in_i.kind;
      s1_word_q.scancode       <= in_i.scancode;
      s1_word_q.query_key      <= in_i.query_key;
      s1_word_q.modifier_index <= in_i.modifier_index;
    end
    if (s1_fire) begin
      out_word_q <= out_word_d;
    end
  end

  // press ring storage
  always_ff @(posedge clk_i) begin
    if (s1_fire && ring_we) begin
      ring_q[wr_ptr_q] <= code;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.popped_code     = out_word_q.popped_code;
  assign out_o.popped_valid    = out_word_q.popped_valid;
  assign out_o.queue_nonempty  = out_word_q.queue_nonempty;
  assign out_o.press_dropped   = out_word_q.press_dropped;
  assign out_o.key_is_down     = out_word_q.key_is_down;
  assign out_o.modifier_active = out_word_q.modifier_active;

endmodule

// ----- tb/tracker_checker.sv -----
`timescale 1ns / 100ps
// tracker_checker: watches both channels of the scancode tracker, predicts each result word
// and compares it with what comes out; depends on kst_pkg

module tracker_checker
  import kst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_word_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o,
  output int        popped_o,
  output int        dropped_o
);

  key_t         code_ring [QueueDepth];
  ptr_t         wr_ptr;
  ptr_t         rd_ptr;
  logic [127:0] key_down;
  logic [2:0]   lock_on;
  logic [2:0]   lock_fresh;
  out_word_t    tracker_results_q [$];
  out_word_t    want;

  function automatic ptr_t advance(input ptr_t p);
    return ptr_t'((32'(p) + 1) % QueueDepth);
  endfunction

  function automatic logic modifier_view(input logic [2:0] sel);
    case (sel)
      ModCtrl:   return key_down[CodeCtrl];
      ModAlt:    return key_down[CodeAlt];
      ModShift:  return key_down[CodeLShift] | key_down[CodeRShift];
      ModMeta:   return key_down[CodeLMeta] | key_down[CodeRMeta];
      ModCaps:   return lock_on[LockCaps];
      ModNum:    return lock_on[LockNum];
      ModScroll: return lock_on[LockScroll];
      default:   return 1'b0;
    endcase
  endfunction

  // updates the tracked state and returns the result word for one input word
  function automatic out_word_t track_word(input in_word_t w);
    out_word_t r;
    key_t      code;
    r = '0;
    code = w.scancode[6:0];
    if (w.kind == KindPop) begin
      if (wr_ptr != rd_ptr) begin
        r.popped_code = code_ring[rd_ptr];
        r.popped_valid = 1'b1;
        rd_ptr = advance(rd_ptr);
      end
    end else if (w.scancode != PrefixByte) begin
      if (!w.scancode[7]) begin
        if (advance(wr_ptr) != rd_ptr) begin
          code_ring[wr_ptr] = code;
          wr_ptr = advance(wr_ptr);
        end else begin
          r.press_dropped = 1'b1;
        end
        if (!lock_on[LockCaps] && code == CodeCaps) begin
          lock_on[LockCaps] = 1'b1;
          lock_fresh[LockCaps] = 1'b1;
        end else if (!lock_on[LockNum] && code == CodeNum) begin
          lock_on[LockNum] = 1'b1;
          lock_fresh[LockNum] = 1'b1;
        end else if (!lock_on[LockScroll] && code == CodeScroll) begin
          lock_on[LockScroll] = 1'b1;
          lock_fresh[LockScroll] = 1'b1;
        end
        key_down[code] = 1'b1;
      end else begin
        // a lock set since the last release survives the next release; any release clears the fresh flags
        if (!lock_fresh[LockCaps] && code == CodeCaps) begin
          lock_on[LockCaps] = 1'b0;
        end else if (!lock_fresh[LockNum] && code == CodeNum) begin
          lock_on[LockNum] = 1'b0;
        end else if (!lock_fresh[LockScroll] && code == CodeScroll) begin
          lock_on[LockScroll] = 1'b0;
        end
        lock_fresh = '0;
        key_down[code] = 1'b0;
      end
    end
    r.queue_nonempty = (wr_ptr != rd_ptr);
    r.key_is_down = key_down[w.query_key];
    r.modifier_active = modifier_view(w.modifier_index);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr = '0;
      rd_ptr = '0;
      key_down = '0;
      lock_on = '0;
      lock_fresh = '0;
      tracker_results_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      popped_o = 0;
      dropped_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (tracker_results_q.size() == 0) begin
          $display("%0t: unexpected result word code=%0d pv=%0d ne=%0d drop=%0d down=%0d mod=%0d",
                   $time, out_word_i.popped_code, out_word_i.popped_valid,
                   out_word_i.queue_nonempty, out_word_i.press_dropped,
                   out_word_i.key_is_down, out_word_i.modifier_active);
          fail_count_o++;
        end else begin
          want = tracker_results_q.pop_front();
          checked_o++;
          if (want.popped_valid) popped_o++;
          if (want.press_dropped) dropped_o++;
          if (out_word_i !== want) begin
            $display("%0t: mismatch expected code=%0d pv=%0d ne=%0d drop=%0d down=%0d mod=%0d",
                     $time, want.popped_code, want.popped_valid, want.queue_nonempty,
                     want.press_dropped, want.key_is_down, want.modifier_active);
            $display("%0t:          actual   code=%0d pv=%0d ne=%0d drop=%0d down=%0d mod=%0d",
                     $time, out_word_i.popped_code, out_word_i.popped_valid,
                     out_word_i.queue_nonempty, out_word_i.press_dropped,
                     out_word_i.key_is_down, out_word_i.modifier_active);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        tracker_results_q.push_back(track_word(in_word_i));
      end
      pending_o = tracker_results_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// testbench: drives scancode bytes and pops into the keyboard scancode tracker with
// random gaps and stalls; depends on kst_pkg, kst_in_if, kst_out_if and tracker_checker

module testbench;
  import kst_pkg::*;

  localparam logic [2:0] ModNone      = 3'd7;
  localparam int         LongHold     = 150;
  localparam int         QuietLimit   = 2000;
  localparam int         RandomChunks = 12;
  localparam int         ChunkWords   = 100;

  logic clk_i;
  logic rst_ni;
  logic tx_gappy;
  logic rx_gappy;
  int   hold_req;
  int   sent_words;
  int   fail_count;
  int   pending;
  int   checked;
  int   popped;
  int   dropped;
  int   quiet;
  key_t held_keys [$];

  kst_in_if  in_ch ();
  kst_out_if out_ch ();

  keyboard_scancode_tracker DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  tracker_checker tracker_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_word_i    ({in_ch.kind, in_ch.scancode, in_ch.query_key, in_ch.modifier_index}),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_word_i   ({out_ch.popped_code, out_ch.popped_valid, out_ch.queue_nonempty,
                    out_ch.press_dropped, out_ch.key_is_down, out_ch.modifier_active}),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .popped_o     (popped),
    .dropped_o    (dropped)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic key_t pick_key();
    if ($urandom_range(0, 9) >= 4) return key_t'($urandom_range(0, 127));
    case ($urandom_range(0, 8))
      0:       return CodeCaps;
      1:       return CodeNum;
      2:       return CodeScroll;
      3:       return CodeCtrl;
      4:       return CodeLShift;
      5:       return CodeRShift;
      6:       return CodeAlt;
      7:       return CodeLMeta;
      default: return CodeRMeta;
    endcase
  endfunction

  task automatic send(input logic kind, input logic [7:0] sc, input key_t q,
                      input logic [2:0] m);
    int gap;
    gap = 0;
    if (tx_gappy && $urandom_range(0, 99) >= 60) gap = idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.scancode <= sc;
    in_ch.query_key <= q;
    in_ch.modifier_index <= m;
    do @(posedge clk_i); while (!in_ch.ready);
    sent_words++;
  endtask

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int hold_left;
    int stall_left;
    int served;
    out_ch.ready = 1'b0;
    hold_left = 0;
    stall_left = 0;
    served = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != served) begin
        served++;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_gappy && $urandom_range(0, 99) < 25) begin
        stall_left = idle_len() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int   chunk;
    int   step;
    int   pop_weight;
    int   pick;
    int   slot;
    key_t k;
    key_t q;
    logic [2:0] m;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KindByte;
    in_ch.scancode = '0;
    in_ch.query_key = '0;
    in_ch.modifier_index = '0;
    tx_gappy = 1'b1;
    rx_gappy = 1'b1;
    hold_req = 0;
    sent_words = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, modifiers, lock toggling, prefix, full queue and pops
    send(KindPop, 8'hA5, 7'd127, ModNone);
    send(KindByte, 8'h00, 7'd0, ModCtrl);
    send(KindByte, 8'h7F, 7'd127, ModAlt);
    send(KindByte, PrefixByte, 7'd127, ModShift);
    send(KindByte, 8'hFF, 7'd127, ModMeta);
    send(KindByte, 8'h80, 7'd0, ModNone);
    send(KindByte, {1'b0, CodeCtrl}, CodeCtrl, ModCtrl);
    send(KindByte, {1'b0, CodeAlt}, CodeAlt, ModAlt);
    send(KindByte, {1'b0, CodeLShift}, CodeRShift, ModShift);
    send(KindByte, {1'b0, CodeRMeta}, CodeLMeta, ModMeta);
    send(KindByte, {1'b0, CodeCaps}, CodeCaps, ModCaps);
    send(KindByte, {1'b1, CodeCaps}, CodeCaps, ModCaps);
    send(KindByte, {1'b0, CodeCaps}, CodeCaps, ModCaps);
    send(KindByte, {1'b1, CodeCaps}, CodeCaps, ModCaps);
    send(KindByte, {1'b0, CodeNum}, CodeNum, ModNum);
    send(KindByte, {1'b0, CodeScroll}, CodeScroll, ModScroll);
    send(KindByte, {1'b1, CodeScroll}, CodeScroll, ModScroll);
    send(KindByte, {1'b1, CodeNum}, CodeNum, ModNum);
    send(KindByte, {1'b0, CodeRShift}, CodeLShift, ModShift);
    send(KindByte, {1'b0, CodeLMeta}, CodeRMeta, ModMeta);
    for (step = 1; step <= 4; step++) begin
      send(KindByte, 8'(step), key_t'(step), ModNone);
    end
    send(KindPop, 8'h00, 7'd0, ModCtrl);
    send(KindPop, 8'hFF, 7'd1, ModNone);

    // key strokes with random content, pops at a varying rate, some noise
    for (chunk = 0; chunk < RandomChunks; chunk++) begin
      tx_gappy = (chunk % 3 != 0);
      rx_gappy = (chunk % 4 != 1);
      if (chunk == 3 || chunk == 9) hold_req++;
      case (chunk % 3)
        0:       pop_weight = 10;
        1:       pop_weight = 30;
        default: pop_weight = 55;
      endcase
      for (step = 0; step < ChunkWords; step++) begin
        case ($urandom_range(0, 2))
          0: q = pick_key();
          1: q = held_keys.size() > 0 ? held_keys[$urandom_range(0, held_keys.size() - 1)]
                                      : key_t'($urandom_range(0, 127));
          default: q = key_t'($urandom_range(0, 127));
        endcase
        m = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < pop_weight) begin
          send(KindPop, 8'($urandom_range(0, 255)), q, m);
        end else if (pick < pop_weight + 8) begin
          send(KindByte, 8'($urandom_range(0, 255)), q, m);
        end else if (pick < pop_weight + 12) begin
          send(KindByte, PrefixByte, q, m);
        end else if (held_keys.size() > 0 && (pick % 2 == 0 || held_keys.size() > 6)) begin
          slot = $urandom_range(0, held_keys.size() - 1);
          k = held_keys[slot];
          held_keys.delete(slot);
          send(KindByte, {1'b1, k}, q, m);
        end else begin
          k = pick_key();
          held_keys.push_back(k);
          send(KindByte, {1'b0, k}, q, m);
        end
      end
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    $display("sent %0d words of presses, releases, prefixes and pops; %0d results checked",
             sent_words, checked);
    $display("%0d codes popped from the queue, %0d presses dropped on a full queue",
             popped, dropped);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/kst_pkg.sv
design/kst_if.sv
design/keyboard_scancode_tracker.sv
tb/tracker_checker.sv
tb/testbench.sv
